### rtl/rhv_pkg.sv
`default_nettype none

package rhv_pkg;

  // Widths of the configuration port and the header fields
  localparam int CFG_INDEX_W = 2;
  localparam int LEN_W       = 24;
  localparam int CFG_DATA_W  = LEN_W;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 4;
  localparam int ERR_W       = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FILE_LENGTH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REJECT_TRAINER = 2'd1;

  // Header byte positions
  localparam logic [POS_W-1:0] POS_PRG       = 4'd4;
  localparam logic [POS_W-1:0] POS_CHR       = 4'd5;
  localparam logic [POS_W-1:0] POS_FLAGS_LOW = 4'd6;
  localparam logic [POS_W-1:0] POS_FLAGS_HI  = 4'd7;
  localparam logic [POS_W-1:0] POS_RAM       = 4'd8;
  localparam logic [POS_W-1:0] POS_VIDEO     = 4'd9;
  localparam logic [POS_W-1:0] POS_FILL0     = 4'd10;
  localparam logic [POS_W-1:0] POS_LAST      = 4'd15;

  // Masks applied to the second flag byte
  localparam logic [BYTE_W-1:0] RESERVED_MASK  = 8'h0E;
  localparam logic [BYTE_W-1:0] MAPPER_HI_MASK = 8'hF0;

  // Bank count floor and the threshold for bank switching
  localparam logic [BYTE_W-1:0] MIN_BANKS    = 8'd1;
  localparam logic [BYTE_W-1:0] FLAT_PRG_MAX = 8'd2;

  // Magic tag at the start of every header
  localparam logic [BYTE_W-1:0] TAG_BYTES [4] = '{8'h4E, 8'h45, 8'h53, 8'h1A};

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 3'd0,
    ERR_SIZE     = 3'd1,
    ERR_TAG      = 3'd2,
    ERR_RESERVED = 3'd3,
    ERR_TRAINER  = 3'd4,
    ERR_VIDEO    = 3'd5,
    ERR_FILL     = 3'd6,
    ERR_MAPPER   = 3'd7
  } err_t;

  typedef struct packed {
    err_t              error_code;
    logic [BYTE_W-1:0] mapper_number;
    logic [BYTE_W-1:0] prg_banks;
    logic [BYTE_W-1:0] chr_banks;
    logic [BYTE_W-1:0] ram_banks;
    logic              video_pal;
    logic              battery_ram;
    logic              trainer_present;
    logic              vs_unisystem;
    logic              playchoice;
    logic              format_two;
    logic              bank_switched;
  } result_t;

endpackage

`default_nettype wire

### rtl/rhv_if.sv
`default_nettype none

// Header byte stream
interface rhv_in_if
  import rhv_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] header_byte;

  modport source (output valid, output header_byte, input ready);
  modport sink   (input valid, input header_byte, output ready);
endinterface

// Decoded header result
interface rhv_out_if
  import rhv_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ERR_W-1:0]  error_code;
  logic [BYTE_W-1:0] mapper_number;
  logic [BYTE_W-1:0] prg_banks;
  logic [BYTE_W-1:0] chr_banks;
  logic [BYTE_W-1:0] ram_banks;
  logic              video_pal;
  logic              battery_ram;
  logic              trainer_present;
  logic              vs_unisystem;
  logic              playchoice;
  logic              format_two;
  logic              bank_switched;

  modport source (
    output valid, input ready,
    output error_code, output mapper_number, output prg_banks, output chr_banks,
    output ram_banks, output video_pal, output battery_ram, output trainer_present,
    output vs_unisystem, output playchoice, output format_two, output bank_switched
  );
  modport sink (
    input valid, output ready,
    input error_code, input mapper_number, input prg_banks, input chr_banks,
    input ram_banks, input video_pal, input battery_ram, input trainer_present,
    input vs_unisystem, input playchoice, input format_two, input bank_switched
  );
endinterface

`default_nettype wire

### rtl/rom_header_validator.sv
// The result is registered on the transfer of header byte 15 and appears in the
// cycle after it. Rate: one header byte per cycle, but byte 15 waits while a
// result is pending; the single result register still takes bytes 0 to 14 of
// the next header while a result waits.
// Reset: synchronous, active low; clears the byte counter, the result valid
// flag and both configuration registers. No clearing pass is needed.
`default_nettype none

module rom_header_validator
  import rhv_pkg::*;
#(
  parameter int MIN_IMAGE_LENGTH = 24592
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  rhv_in_if.sink                      in_ch,
  rhv_out_if.source                   out_ch
);

  localparam int LEN_CMP_W = LEN_W + 1;
  localparam logic [LEN_CMP_W-1:0] MIN_LEN = LEN_CMP_W'(MIN_IMAGE_LENGTH);

  logic [LEN_W-1:0]  file_length_r;
  logic              reject_trainer_r;

  logic [POS_W-1:0]  pos_r;
  logic              tag_bad_r;
  logic              fill_nz_r;
  logic [BYTE_W-1:0] prg_r;
  logic [BYTE_W-1:0] chr_r;
  logic [BYTE_W-1:0] ram_r;
  logic [BYTE_W-1:0] flags_low_r;
  logic [BYTE_W-1:0] flags_high_r;
  logic [BYTE_W-1:0] video_r;

  logic              out_valid_r;
  result_t           res_r;
  result_t           res_nxt;

  logic              in_xfer;
  logic              last_byte;
  logic              tag_bad;
  logic              byte_nz;

  // Configuration writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r    <= '0;
      reject_trainer_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILE_LENGTH:    file_length_r    <= cfg_data[LEN_W-1:0];
        CFG_REJECT_TRAINER: reject_trainer_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: only the last byte of a header has to wait for the result slot
  assign last_byte   = (pos_r == POS_LAST);
  assign in_ch.ready = !last_byte || !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign tag_bad = (in_ch.header_byte != TAG_BYTES[pos_r[1:0]]);
  assign byte_nz = (in_ch.header_byte != '0);

  // Byte counter, wraps after byte 15
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_xfer) begin
      pos_r <= pos_r + POS_W'(1);
    end
  end

  // Capture of header fields by position
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (pos_r[POS_W-1:2] == '0) begin
        // tag bytes; first one restarts the mismatch flag
        tag_bad_r <= (pos_r[1:0] == 2'd0) ? tag_bad : (tag_bad_r | tag_bad);
      end else begin
        case (pos_r)
          POS_PRG:       prg_r        <= in_ch.header_byte;
          POS_CHR:       chr_r        <= in_ch.header_byte;
          POS_FLAGS_LOW: flags_low_r  <= in_ch.header_byte;
          POS_FLAGS_HI:  flags_high_r <= in_ch.header_byte;
          POS_RAM:       ram_r        <= in_ch.header_byte;
          POS_VIDEO:     video_r      <= in_ch.header_byte;
          POS_FILL0:     fill_nz_r    <= byte_nz;
          POS_LAST:      ;  // never checked
          default:       fill_nz_r    <= fill_nz_r | byte_nz;
        endcase
      end
    end
  end

  // Decode and first-error priority
  always_comb begin
    res_nxt.prg_banks       = (prg_r == '0) ? MIN_BANKS : prg_r;
    res_nxt.ram_banks       = (ram_r == '0) ? MIN_BANKS : ram_r;
    res_nxt.chr_banks       = chr_r;
    res_nxt.mapper_number   = (flags_low_r >> 4) | (flags_high_r & MAPPER_HI_MASK);
    res_nxt.video_pal       = video_r[0];
    res_nxt.battery_ram     = flags_low_r[1];
    res_nxt.trainer_present = flags_low_r[2];
    res_nxt.vs_unisystem    = flags_high_r[0];
    res_nxt.playchoice      = flags_high_r[1];
    res_nxt.format_two      = flags_high_r[2];
    res_nxt.bank_switched   = (res_nxt.prg_banks > FLAT_PRG_MAX);

    if ({1'b0, file_length_r} < MIN_LEN) begin
      res_nxt.error_code = ERR_SIZE;
    end else if (tag_bad_r) begin
      res_nxt.error_code = ERR_TAG;
    end else if ((flags_high_r & RESERVED_MASK) != '0) begin
      res_nxt.error_code = ERR_RESERVED;
    end else if (reject_trainer_r && flags_low_r[2]) begin
      res_nxt.error_code = ERR_TRAINER;
    end else if (video_r[BYTE_W-1:1] != '0) begin
      res_nxt.error_code = ERR_VIDEO;
    end else if (fill_nz_r && !flags_high_r[2]) begin
      res_nxt.error_code = ERR_FILL;
    end else if (res_nxt.mapper_number != '0) begin
      res_nxt.error_code = ERR_MAPPER;
    end else begin
      res_nxt.error_code = ERR_NONE;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last_byte) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.error_code      = res_r.error_code;
  assign out_ch.mapper_number   = res_r.mapper_number;
  assign out_ch.prg_banks       = res_r.prg_banks;
  assign out_ch.chr_banks       = res_r.chr_banks;
  assign out_ch.ram_banks       = res_r.ram_banks;
  assign out_ch.video_pal       = res_r.video_pal;
  assign out_ch.battery_ram     = res_r.battery_ram;
  assign out_ch.trainer_present = res_r.trainer_present;
  assign out_ch.vs_unisystem    = res_r.vs_unisystem;
  assign out_ch.playchoice      = res_r.playchoice;
  assign out_ch.format_two      = res_r.format_two;
  assign out_ch.bank_switched   = res_r.bank_switched;

endmodule

`default_nettype wire

### rtl/rhv_checker.sv
`default_nettype none

module rhv_checker
  import rhv_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ERR_W-1:0]  error_code,
  input wire logic [BYTE_W-1:0] mapper_number,
  input wire logic [BYTE_W-1:0] prg_banks,
  input wire logic [BYTE_W-1:0] ram_banks,
  input wire logic              format_two,
  input wire logic              bank_switched
);

  // A pending result stays until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // A new result only follows an input transfer
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without a header byte");

  // PRG and RAM bank counts raised from zero and bank switching agrees with them
  a_banks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (prg_banks != '0) && (ram_banks != '0)
                  && (bank_switched == (prg_banks > FLAT_PRG_MAX)))
    else $error("inconsistent bank fields");

  // A clean header has mapper zero and no extended format
  a_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (error_code == ERR_NONE) |-> (mapper_number == '0) && !format_two)
    else $error("accepted header with mapper or extended format");

endmodule

bind rom_header_validator rhv_checker u_rhv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .error_code    (out_ch.error_code),
  .mapper_number (out_ch.mapper_number),
  .prg_banks     (out_ch.prg_banks),
  .ram_banks     (out_ch.ram_banks),
  .format_two    (out_ch.format_two),
  .bank_switched (out_ch.bank_switched)
);

`default_nettype wire

### tb/sv/header_result_checker.sv
`timescale 1ns / 1ps

module header_result_checker
  import rhv_pkg::*;
#(
  parameter int MIN_IMAGE_LENGTH = 24592
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rhv_in_if                      in_ch,
  rhv_out_if                     out_ch,
  output int                     mismatches,
  output int                     pending
);

  localparam int MAX_REPORTS = 10;

  // Shadow copy of the configuration registers
  logic [LEN_W-1:0]  image_len;
  logic              trainer_rejected;

  // Shadow copy of the per-header state
  logic [POS_W-1:0]  byte_pos;
  logic              tag_bad;
  logic [BYTE_W-1:0] flags_lo;
  logic [BYTE_W-1:0] flags_hi;
  logic [BYTE_W-1:0] prg_raw;
  logic [BYTE_W-1:0] chr_raw;
  logic [BYTE_W-1:0] ram_raw;
  logic [BYTE_W-1:0] video_raw;
  logic              fill_dirty;

  // Decoded headers still waiting for their result transfer
  result_t decoded_due [$];

  function automatic void show_result(input string label, input result_t r);
    $write("  %s err=%0d mapper=%02h prg=%02h chr=%02h ram=%02h",
           label, r.error_code, r.mapper_number, r.prg_banks, r.chr_banks, r.ram_banks);
    $display(" pal=%b bat=%b trn=%b vs=%b pc=%b fmt2=%b bsw=%b",
             r.video_pal, r.battery_ram, r.trainer_present, r.vs_unisystem, r.playchoice,
             r.format_two, r.bank_switched);
  endfunction

  // Take one header byte; after the last one, decode the header
  task automatic absorb_header_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    logic    tag_miss;
    tag_miss = (b != TAG_BYTES[byte_pos[1:0]]);
    if (byte_pos < POS_PRG) begin
      tag_bad = (byte_pos == '0) ? tag_miss : (tag_bad | tag_miss);
    end else if (byte_pos == POS_PRG) begin
      prg_raw = b;
    end else if (byte_pos == POS_CHR) begin
      chr_raw = b;
    end else if (byte_pos == POS_FLAGS_LOW) begin
      flags_lo = b;
    end else if (byte_pos == POS_FLAGS_HI) begin
      flags_hi = b;
    end else if (byte_pos == POS_RAM) begin
      ram_raw = b;
    end else if (byte_pos == POS_VIDEO) begin
      video_raw = b;
    end else if (byte_pos == POS_FILL0) begin
      fill_dirty = (b != '0);
    end else if (byte_pos < POS_LAST) begin
      fill_dirty = fill_dirty | (b != '0);
    end

    if (byte_pos == POS_LAST) begin
      r.prg_banks       = (prg_raw == '0) ? MIN_BANKS : prg_raw;
      r.ram_banks       = (ram_raw == '0) ? MIN_BANKS : ram_raw;
      r.chr_banks       = chr_raw;
      // mapper: low nibble from the first flag byte, high nibble from the second
      r.mapper_number   = (flags_lo >> 4) | (flags_hi & MAPPER_HI_MASK);
      r.video_pal       = video_raw[0];
      r.battery_ram     = flags_lo[1];
      r.trainer_present = flags_lo[2];
      r.vs_unisystem    = flags_hi[0];
      r.playchoice      = flags_hi[1];
      r.format_two      = flags_hi[2];
      r.bank_switched   = (r.prg_banks > FLAT_PRG_MAX);

      // first failing check wins
      if (image_len < MIN_IMAGE_LENGTH) begin
        r.error_code = ERR_SIZE;
      end else if (tag_bad) begin
        r.error_code = ERR_TAG;
      end else if ((flags_hi & RESERVED_MASK) != '0) begin
        r.error_code = ERR_RESERVED;
      end else if (trainer_rejected && flags_lo[2]) begin
        r.error_code = ERR_TRAINER;
      end else if (video_raw > 8'd1) begin
        r.error_code = ERR_VIDEO;
      end else if (fill_dirty && !flags_hi[2]) begin
        r.error_code = ERR_FILL;
      end else if (r.mapper_number != '0) begin
        r.error_code = ERR_MAPPER;
      end else begin
        r.error_code = ERR_NONE;
      end
      decoded_due.push_back(r);
    end
    byte_pos = byte_pos + 1'b1;
  endtask

  // Compare one result transfer with the oldest decoded header
  task automatic check_result();
    result_t got;
    result_t want;
    got.error_code      = err_t'(out_ch.error_code);
    got.mapper_number   = out_ch.mapper_number;
    got.prg_banks       = out_ch.prg_banks;
    got.chr_banks       = out_ch.chr_banks;
    got.ram_banks       = out_ch.ram_banks;
    got.video_pal       = out_ch.video_pal;
    got.battery_ram     = out_ch.battery_ram;
    got.trainer_present = out_ch.trainer_present;
    got.vs_unisystem    = out_ch.vs_unisystem;
    got.playchoice      = out_ch.playchoice;
    got.format_two      = out_ch.format_two;
    got.bank_switched   = out_ch.bank_switched;

    if (decoded_due.size() == 0) begin
      if (mismatches < MAX_REPORTS) begin
        $display("%0t: header result with no header behind it", $time);
        show_result("got     ", got);
      end
      mismatches++;
    end else begin
      want = decoded_due.pop_front();
      if (got.error_code !== want.error_code || got.mapper_number !== want.mapper_number ||
          got.prg_banks !== want.prg_banks || got.chr_banks !== want.chr_banks ||
          got.ram_banks !== want.ram_banks || got.video_pal !== want.video_pal ||
          got.battery_ram !== want.battery_ram ||
          got.trainer_present !== want.trainer_present ||
          got.vs_unisystem !== want.vs_unisystem || got.playchoice !== want.playchoice ||
          got.format_two !== want.format_two || got.bank_switched !== want.bank_switched) begin
        if (mismatches < MAX_REPORTS) begin
          $display("%0t: header result differs", $time);
          show_result("expected", want);
          show_result("got     ", got);
        end
        mismatches++;
      end
    end
  endtask

  // Result transfer first, then the byte transfer, then any register write:
  // a write lands after the byte taken on the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      image_len        = '0;
      trainer_rejected = 1'b0;
      byte_pos         = '0;
      tag_bad          = 1'b0;
      flags_lo         = '0;
      flags_hi         = '0;
      prg_raw          = '0;
      chr_raw          = '0;
      ram_raw          = '0;
      video_raw        = '0;
      fill_dirty       = 1'b0;
      mismatches       = 0;
      decoded_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result();
      end
      if (in_ch.valid && in_ch.ready) begin
        absorb_header_byte(in_ch.header_byte);
      end
      // spare indexes are ignored
      if (cfg_we) begin
        if (cfg_index == CFG_FILE_LENGTH) begin
          image_len = cfg_data[LEN_W-1:0];
        end else if (cfg_index == CFG_REJECT_TRAINER) begin
          trainer_rejected = cfg_data[0];
        end
      end
    end
    pending = decoded_due.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rhv_pkg::*;

  localparam int MIN_LEN    = 24592;
  localparam int HEADER_LEN = 16;
  localparam int PHASES     = 9;
  localparam int LONG_HOLD  = 300;

  // Indexes that decode to no register
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int  tx_idle_pct  = 0;
  int  rx_idle_pct  = 0;
  bit  hold_off_req = 1'b0;
  int  mismatches;
  int  pending;

  // Bytes of generated headers not yet offered
  logic [BYTE_W-1:0] byte_stream [$];

  rhv_in_if  in_ch ();
  rhv_out_if out_ch ();

  rom_header_validator #(.MIN_IMAGE_LENGTH(MIN_LEN)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  header_result_checker #(.MIN_IMAGE_LENGTH(MIN_LEN)) result_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous ceiling, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one byte, with random gaps, and wait for its transfer
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.header_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Caller drops cfg_we after the last write of a batch
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // Stop offering, wait for every decoded header, then a few quiet cycles
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [BYTE_W-1:0] hdr [HEADER_LEN];
    logic [LEN_W-1:0]  len;
    logic              rej;
    int                n;
    int                k;
    int                p;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.header_byte <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All-ones header under the reset settings: size error, every field at its top
    repeat (HEADER_LEN) send_byte(8'hFF);
    settle();

    // Clean header with zero counts; the PRG and RAM counts must come back raised to one
    cfg_write(CFG_FILE_LENGTH, CFG_DATA_W'(MIN_LEN));
    cfg_write(CFG_REJECT_TRAINER, CFG_DATA_W'(1));
    cfg_we <= 1'b0;
    for (k = 0; k < 4; k++) send_byte(TAG_BYTES[k]);
    repeat (HEADER_LEN - 4) send_byte('0);
    settle();

    // Random phases; a phase often ends mid-header, so writes also land mid-header
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin len = LEN_W'(MIN_LEN - 1); rej = 1'b0; end
        1: begin len = LEN_W'(MIN_LEN);     rej = 1'b1; end
        2: begin len = '1;                  rej = 1'b0; end
        3: begin len = LEN_W'($urandom_range(24'hFFFFFF, MIN_LEN)); rej = 1'b1; end
        4: begin len = '0;                  rej = 1'b1; end
        default: begin
          len = ($urandom_range(3) == 0) ? LEN_W'($urandom)
                                         : LEN_W'($urandom_range(24'hFFFFFF, MIN_LEN));
          rej = 1'($urandom);
        end
      endcase
      if (p % 3 == 0) begin
        cfg_write(CFG_SPARE_A, CFG_DATA_W'($urandom));
        cfg_write(CFG_SPARE_B, CFG_DATA_W'($urandom));
      end
      cfg_write(CFG_FILE_LENGTH, CFG_DATA_W'(len));
      cfg_write(CFG_REJECT_TRAINER, CFG_DATA_W'(rej));
      cfg_we <= 1'b0;

      tx_idle_pct = (p < 3) ? 33 : (p < 6) ? 51 : 0;
      rx_idle_pct = (p < 3) ? 51 : (p < 6) ? 33 : 0;
      if (p == 4) hold_off_req = 1'b1;

      n = 120 + $urandom_range(15);
      repeat (n) begin
        if (byte_stream.size() == 0) begin
          if ($urandom_range(9) == 0) begin
            // raw noise
            for (k = 0; k < HEADER_LEN; k++) hdr[k] = 8'($urandom);
          end else begin
            // well-formed base with random content
            for (k = 0; k < 4; k++) hdr[k] = TAG_BYTES[k];
            hdr[POS_PRG]       = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
            hdr[POS_CHR]       = 8'($urandom);
            hdr[POS_FLAGS_LOW] = {4'h0, 4'($urandom)};
            hdr[POS_FLAGS_HI]  = {7'h00, 1'($urandom)};
            hdr[POS_RAM]       = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
            hdr[POS_VIDEO]     = 8'($urandom_range(1));
            for (k = POS_FILL0; k < POS_LAST; k++) hdr[k] = '0;
            hdr[POS_LAST]      = 8'($urandom);
            // each fault one time in six, so several often meet in one header
            if ($urandom_range(5) == 0) hdr[$urandom_range(3)] ^= 8'($urandom_range(255, 1));
            if ($urandom_range(5) == 0) begin
              hdr[POS_FLAGS_HI] |= {4'h0, 3'($urandom_range(7, 1)), 1'b0};
            end
            if ($urandom_range(5) == 0) hdr[POS_VIDEO] = 8'($urandom_range(255, 2));
            if ($urandom_range(5) == 0) hdr[$urandom_range(14, 10)] = 8'($urandom_range(255, 1));
            if ($urandom_range(5) == 0) hdr[POS_FLAGS_LOW][7:4] = 4'($urandom);
            if ($urandom_range(5) == 0) hdr[POS_FLAGS_HI][7:4] = 4'($urandom);
          end
          for (k = 0; k < HEADER_LEN; k++) byte_stream.push_back(hdr[k]);
        end
        send_byte(byte_stream.pop_front());
      end
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
